@@ rtl/sfla_pkg.sv @@
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared constants and types of the slot free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int REQ_W  = 2;
  localparam int TOT_W  = 32;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_REJ = 1'b1;

  // Access to the free stack, driven combinationally by the allocator
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
    logic              clr;
    logic [CNT_W-1:0]  clr_n;
  } stack_req_t;

endpackage

@@ rtl/sfla_ram.sv @@
// ----------------------------------------------------------------------------
// sfla_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sfla_stack.sv @@
// ----------------------------------------------------------------------------
// sfla_stack
// Free stack storage: RAM plus per-entry valid bits. An entry that is not
// valid reads as its own address, which is its refill value.
// ----------------------------------------------------------------------------
module sfla_stack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfla_pkg::stack_req_t      req,
  output logic [sfla_pkg::SLOT_W-1:0] rdata
);
  import sfla_pkg::*;

  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic              rd_valid_r;
  logic [SLOT_W-1:0] rd_addr_r;
  logic [SLOT_W-1:0] ram_q;

  sfla_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (req.we),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .raddr(req.raddr),
    .rdata(ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    // Pool reset: drop every entry below the new size back to its refill value
    for (int i = 0; i < SLOTS; i++) begin
      if (req.clr && (CNT_W'(i) < req.clr_n)) begin
        valid_nxt[i] = 1'b0;
      end
    end
    if (req.we) begin
      valid_nxt[req.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= valid_r[req.raddr];
    rd_addr_r  <= req.raddr;
  end

  assign rdata = rd_valid_r ? ram_q : rd_addr_r;

endmodule

@@ rtl/slot_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// slot_free_list_allocator
// Sequence: alloc runs S_RD (stack RAM read) then S_FIN; reject and pool reset go
//   straight to S_FIN; free runs S_PUSH (one stack push per cycle) then S_FIN.
// Flow: one request at a time; the next word is taken once the current
//   result sits in the output register, so an alloc ends before the next is taken.
// Reset (rst_n low, synchronous): stack refilled to 0..255 via valid bits,
//   pool_size 256, all counters zero.
// ----------------------------------------------------------------------------
module slot_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sfla_pkg::REQ_W-1:0]   in_req_type,
  input  logic [sfla_pkg::CNT_W-1:0]   in_count,
  input  logic [sfla_pkg::SLOT_W-1:0]  in_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [sfla_pkg::SLOT_W-1:0]  out_slot_index,
  output logic [sfla_pkg::CNT_W-1:0]   out_free_slots,
  output logic [sfla_pkg::CNT_W-1:0]   out_allocated_slots,
  output logic [sfla_pkg::CNT_W-1:0]   out_peak_slots,
  output logic [sfla_pkg::TOT_W-1:0]   out_alloc_total,
  input  logic                         cfg_we,
  input  logic [sfla_pkg::CNT_W-1:0]   cfg_wdata
);
  import sfla_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  pool_size_r, pool_size_nxt;
  logic [CNT_W-1:0]  stack_top_r, stack_top_nxt;
  logic [CNT_W-1:0]  in_use_r, in_use_nxt;
  logic [CNT_W-1:0]  high_water_r, high_water_nxt;
  logic [TOT_W-1:0]  alloc_total_r, alloc_total_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0] push_val_r, push_val_nxt;
  logic              res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;

  logic              o_status_r, o_status_nxt;
  logic [SLOT_W-1:0] o_slot_r, o_slot_nxt;
  logic [CNT_W-1:0]  o_free_r, o_free_nxt;
  logic [CNT_W-1:0]  o_alloc_r, o_alloc_nxt;
  logic [CNT_W-1:0]  o_peak_r, o_peak_nxt;
  logic [TOT_W-1:0]  o_total_r, o_total_nxt;

  stack_req_t        sreq;
  logic [SLOT_W-1:0] stack_rdata;

  logic [CNT_W-1:0]  eff_size;
  logic [CNT_W-1:0]  pos;
  logic              alloc_ok;
  logic              free_ok;
  logic [CNT_W-1:0]  use_sum;

  sfla_stack u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sreq),
    .rdata(stack_rdata)
  );

  always_comb begin
    if (pool_size_r == '0) begin
      eff_size = CNT_W'(1);
    end else if (pool_size_r > CNT_W'(SLOTS)) begin
      eff_size = CNT_W'(SLOTS);
    end else begin
      eff_size = pool_size_r;
    end
  end

  assign pos      = stack_top_r - in_count;
  assign alloc_ok = (in_count != '0) && (in_count <= stack_top_r);
  assign free_ok  = (in_count != '0)
                 && (({2'b00, in_index} + {1'b0, in_count}) <= {1'b0, eff_size})
                 && (in_count <= in_use_r)
                 && (({1'b0, stack_top_r} + {1'b0, in_count}) <= (CNT_W + 1)'(SLOTS));
  assign use_sum  = in_use_r + cnt_r;

  always_comb begin
    state_nxt       = state_r;
    pool_size_nxt   = pool_size_r;
    stack_top_nxt   = stack_top_r;
    in_use_nxt      = in_use_r;
    high_water_nxt  = high_water_r;
    alloc_total_nxt = alloc_total_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    pos_nxt         = pos_r;
    push_val_nxt    = push_val_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    o_status_nxt    = o_status_r;
    o_slot_nxt      = o_slot_r;
    o_free_nxt      = o_free_r;
    o_alloc_nxt     = o_alloc_r;
    o_peak_nxt      = o_peak_r;
    o_total_nxt     = o_total_r;

    sreq        = '0;
    sreq.raddr  = pos[SLOT_W-1:0];
    sreq.waddr  = stack_top_r[SLOT_W-1:0];
    sreq.wdata  = push_val_r;
    sreq.clr_n  = eff_size;

    if (cfg_we) begin
      pool_size_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt        = in_count;
          res_status_nxt = ST_REJ;
          res_slot_nxt   = '0;
          state_nxt      = S_FIN;
          case (in_req_type)
            REQ_ALLOC: begin
              if (alloc_ok) begin
                pos_nxt   = pos;
                state_nxt = S_RD;
              end
            end
            REQ_FREE: begin
              if (free_ok) begin
                rem_nxt      = in_count;
                push_val_nxt = in_index;
                state_nxt    = S_PUSH;
              end
            end
            REQ_RESET: begin
              sreq.clr       = 1'b1;
              stack_top_nxt  = eff_size;
              in_use_nxt     = '0;
              res_status_nxt = ST_OK;
            end
            default: begin
              res_status_nxt = ST_REJ;
            end
          endcase
        end
      end
      S_RD: begin
        res_slot_nxt    = stack_rdata;
        res_status_nxt  = ST_OK;
        stack_top_nxt   = pos_r;
        in_use_nxt      = use_sum;
        alloc_total_nxt = alloc_total_r + TOT_W'(1);
        if (use_sum > high_water_r) begin
          high_water_nxt = use_sum;
        end
        state_nxt = S_FIN;
      end
      S_PUSH: begin
        sreq.we       = 1'b1;
        stack_top_nxt = stack_top_r + CNT_W'(1);
        push_val_nxt  = push_val_r + SLOT_W'(1);
        rem_nxt       = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          in_use_nxt     = in_use_r - cnt_r;
          res_status_nxt = ST_OK;
          state_nxt      = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_status_r;
          o_slot_nxt    = res_slot_r;
          o_free_nxt    = stack_top_r;
          o_alloc_nxt   = in_use_r;
          o_peak_nxt    = high_water_r;
          o_total_nxt   = alloc_total_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pool_size_r   <= CNT_W'(SLOTS);
      stack_top_r   <= CNT_W'(SLOTS);
      in_use_r      <= '0;
      high_water_r  <= '0;
      alloc_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pool_size_r   <= pool_size_nxt;
      stack_top_r   <= stack_top_nxt;
      in_use_r      <= in_use_nxt;
      high_water_r  <= high_water_nxt;
      alloc_total_r <= alloc_total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    rem_r        <= rem_nxt;
    pos_r        <= pos_nxt;
    push_val_r   <= push_val_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    o_status_r   <= o_status_nxt;
    o_slot_r     <= o_slot_nxt;
    o_free_r     <= o_free_nxt;
    o_alloc_r    <= o_alloc_nxt;
    o_peak_r     <= o_peak_nxt;
    o_total_r    <= o_total_nxt;
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_slot_index      = o_slot_r;
  assign out_free_slots      = o_free_r;
  assign out_allocated_slots = o_alloc_r;
  assign out_peak_slots      = o_peak_r;
  assign out_alloc_total     = o_total_r;

endmodule

@@ rtl/sfla_checker.sv @@
// ----------------------------------------------------------------------------
// sfla_checker
// Port-level checks on the allocator's result words.
// ----------------------------------------------------------------------------
module sfla_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic [sfla_pkg::SLOT_W-1:0]  out_slot_index,
  input logic [sfla_pkg::CNT_W-1:0]   out_free_slots,
  input logic [sfla_pkg::CNT_W-1:0]   out_allocated_slots,
  input logic [sfla_pkg::CNT_W-1:0]   out_peak_slots,
  input logic [sfla_pkg::TOT_W-1:0]   out_alloc_total
);
  import sfla_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_free_slots)
      && $stable(out_alloc_total) && $stable(out_status))
    else $error("result word changed while stalled");

  // Free plus allocated never exceeds the stack depth
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_free_slots} + {1'b0, out_allocated_slots})
      <= (CNT_W + 1)'(SLOTS))
    else $error("free and allocated slots exceed the pool");

  // Peak tracks at least the current allocation
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_slots >= out_allocated_slots)
    else $error("peak below allocated count");

  // A rejected request reports no slot
  a_rej_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REJ) |-> out_slot_index == '0)
    else $error("rejected request carries a slot index");

endmodule

bind slot_free_list_allocator sfla_checker u_sfla_checker (.*);

@@ test/slot_pool_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_checker
// Watches the request, result and pool-size ports of the allocator, keeps its
// own copy of the free stack and counters, and compares every result word.
// ----------------------------------------------------------------------------
module slot_pool_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [sfla_pkg::REQ_W-1:0]   in_req_type,
  input  logic [sfla_pkg::CNT_W-1:0]   in_count,
  input  logic [sfla_pkg::SLOT_W-1:0]  in_index,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_status,
  input  logic [sfla_pkg::SLOT_W-1:0]  out_slot_index,
  input  logic [sfla_pkg::CNT_W-1:0]   out_free_slots,
  input  logic [sfla_pkg::CNT_W-1:0]   out_allocated_slots,
  input  logic [sfla_pkg::CNT_W-1:0]   out_peak_slots,
  input  logic [sfla_pkg::TOT_W-1:0]   out_alloc_total,
  input  logic                         cfg_we,
  input  logic [sfla_pkg::CNT_W-1:0]   cfg_wdata,
  output int                           mismatches,
  output int                           outstanding
);

  import sfla_pkg::*;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  free_slots;
    logic [CNT_W-1:0]  allocated_slots;
    logic [CNT_W-1:0]  peak_slots;
    logic [TOT_W-1:0]  alloc_total;
  } pool_result_t;

  logic [SLOT_W-1:0] free_stack [SLOTS];
  int unsigned       stack_top;
  int unsigned       in_use;
  int unsigned       high_water;
  logic [TOT_W-1:0]  alloc_count;
  logic [CNT_W-1:0]  pool_size_reg;

  pool_result_t      expected_results [$];
  pool_result_t      want_result;
  pool_result_t      new_result;

  // Register value saturated to 1..SLOTS
  function automatic int unsigned usable_slots();
    if (pool_size_reg == 0) return 1;
    if (pool_size_reg > SLOTS) return SLOTS;
    return pool_size_reg;
  endfunction

  task automatic refill_stack();
    int unsigned n;
    int unsigned i;
    n = usable_slots();
    for (i = 0; i < n; i++) free_stack[i] = SLOT_W'(i);
    stack_top = n;
    in_use    = 0;
  endtask

  task automatic reset_pool_model();
    int unsigned i;
    pool_size_reg = CNT_W'(SLOTS);
    for (i = 0; i < SLOTS; i++) free_stack[i] = SLOT_W'(i);
    refill_stack();
    high_water  = 0;
    alloc_count = '0;
  endtask

  task automatic serve_request(input  logic [REQ_W-1:0]  req,
                               input  logic [CNT_W-1:0]  cnt,
                               input  logic [SLOT_W-1:0] idx,
                               output pool_result_t      res);
    int unsigned i;
    res        = '0;
    res.status = ST_REJ;
    case (req)
      REQ_ALLOC: begin
        if (cnt != 0 && cnt <= stack_top) begin
          stack_top      = stack_top - cnt;
          res.slot_index = free_stack[stack_top];
          in_use         = in_use + cnt;
          alloc_count    = alloc_count + 1'b1;
          if (in_use > high_water) high_water = in_use;
          res.status     = ST_OK;
        end
      end
      REQ_FREE: begin
        // stack_top + in_use never passes SLOTS once over-free is refused
        if (cnt != 0 && idx + cnt <= usable_slots() && cnt <= in_use &&
            stack_top + cnt <= SLOTS) begin
          for (i = 0; i < cnt; i++) begin
            free_stack[stack_top] = SLOT_W'(idx + i);
            stack_top++;
          end
          in_use     = in_use - cnt;
          res.status = ST_OK;
        end
      end
      REQ_RESET: begin
        refill_stack();
        res.status = ST_OK;
      end
      default: ;
    endcase
    res.free_slots      = CNT_W'(stack_top);
    res.allocated_slots = CNT_W'(in_use);
    res.peak_slots      = CNT_W'(high_water);
    res.alloc_total     = alloc_count;
  endtask

  task automatic check_field(input string name, input logic [TOT_W-1:0] want,
                             input logic [TOT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_pool_model();
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) pool_size_reg = cfg_wdata;
      // compare before queuing: a word taken this edge belongs to an older request
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no request waiting");
          mismatches++;
        end else begin
          want_result = expected_results.pop_front();
          check_field("status", want_result.status, out_status);
          check_field("slot_index", want_result.slot_index, out_slot_index);
          check_field("free_slots", want_result.free_slots, out_free_slots);
          check_field("allocated_slots", want_result.allocated_slots,
                      out_allocated_slots);
          check_field("peak_slots", want_result.peak_slots, out_peak_slots);
          check_field("alloc_total", want_result.alloc_total, out_alloc_total);
        end
      end
      if (in_valid && in_ready) begin
        serve_request(in_req_type, in_count, in_index, new_result);
        expected_results.push_back(new_result);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ test/slot_free_list_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_free_list_allocator_tb
// Directed corner requests, then phases of mostly legal alloc/free traffic
// under several pool sizes, random gaps on both sides, one long output stall
// in phase 2, a full drain before each phase. The checker compares every result.
// ----------------------------------------------------------------------------
module slot_free_list_allocator_tb;

  import sfla_pkg::*;

  localparam int               CLK_PERIOD  = 10;
  localparam int               RESET_CYCLES = 7;
  localparam int               CYCLE_LIMIT = 4000000;
  localparam int               PHASES      = 8;
  localparam int               PHASE_ITEMS = 180;
  localparam int               LONG_STALL  = 400;
  localparam int               DRAIN_CYCLES = 20;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [CNT_W-1:0]    in_count = '0;
  logic [SLOT_W-1:0]   in_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_status;
  logic [SLOT_W-1:0]   out_slot_index;
  logic [CNT_W-1:0]    out_free_slots;
  logic [CNT_W-1:0]    out_allocated_slots;
  logic [CNT_W-1:0]    out_peak_slots;
  logic [TOT_W-1:0]    out_alloc_total;
  logic                cfg_we = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  int                  mismatches;
  int                  outstanding;

  // Receiver control
  logic                steady = 1'b0;
  int                  stall_asked = 0;
  int                  stall_taken = 0;
  int                  stall_left = 0;

  // Rough pool occupancy, only to steer requests toward success
  int                  held = 0;
  int                  capacity = SLOTS;
  int                  pool_now = SLOTS;

  int                  cycles = 0;
  int                  phase;
  int                  n;
  logic [CNT_W-1:0]    pool_plan [PHASES];

  always #(CLK_PERIOD / 2) clk = ~clk;

  slot_free_list_allocator i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_count            (in_count),
    .in_index            (in_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_free_slots      (out_free_slots),
    .out_allocated_slots (out_allocated_slots),
    .out_peak_slots      (out_peak_slots),
    .out_alloc_total     (out_alloc_total),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  slot_pool_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_count            (in_count),
    .in_index            (in_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_free_slots      (out_free_slots),
    .out_allocated_slots (out_allocated_slots),
    .out_peak_slots      (out_peak_slots),
    .out_alloc_total     (out_alloc_total),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  // Result sink: random back-pressure, one long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_asked != stall_taken) begin
      out_ready   <= 1'b0;
      stall_left  <= LONG_STALL - 1;
      stall_taken <= stall_asked;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one request word and hold it until taken
  task automatic issue_request(input logic [REQ_W-1:0]  req,
                               input logic [CNT_W-1:0]  cnt,
                               input logic [SLOT_W-1:0] idx);
    int gap;
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_count    <= cnt;
    in_index    <= idx;
    do @(posedge clk); while (!in_ready);
    case (req)
      REQ_ALLOC: if (cnt != 0 && cnt <= capacity - held) held += cnt;
      REQ_FREE:  if (cnt != 0 && idx + cnt <= pool_now && cnt <= held) held -= cnt;
      REQ_RESET: begin
        capacity = pool_now;
        held     = 0;
      end
      default: ;
    endcase
  endtask

  // Stop offering and let every result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pool_now  = (value == 0) ? 1 : (value > SLOTS) ? SLOTS : value;
  endtask

  task automatic random_request();
    int roll;
    int spare;
    int cnt;
    int idx;
    roll  = $urandom_range(99);
    spare = capacity - held;
    cnt   = 1;
    idx   = 0;
    if (roll < 40) begin
      if (spare > 0) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(spare, 1)
                                       : $urandom_range((spare < 12) ? spare : 12, 1);
      end
      issue_request(REQ_ALLOC, CNT_W'(cnt), SLOT_W'($urandom));
    end else if (roll < 75) begin
      if (held > 0) begin
        cnt = ($urandom_range(9) == 0) ? held
                                       : $urandom_range((held < 12) ? held : 12, 1);
      end
      if (cnt <= pool_now) idx = $urandom_range(pool_now - cnt, 0);
      issue_request(REQ_FREE, CNT_W'(cnt), SLOT_W'(idx));
    end else if (roll < 80) begin
      issue_request(REQ_RESET, CNT_W'($urandom), SLOT_W'($urandom));
    end else begin
      // malformed and refused requests
      case ($urandom_range(4))
        0: issue_request(REQ_UNKNOWN, CNT_W'($urandom), SLOT_W'($urandom));
        1: issue_request($urandom_range(1) ? REQ_FREE : REQ_ALLOC, '0, SLOT_W'($urandom));
        2: issue_request(REQ_ALLOC, CNT_W'($urandom_range(511, spare + 1)),
                         SLOT_W'($urandom));
        3: issue_request(REQ_FREE, CNT_W'($urandom_range(511, 1)), SLOT_W'($urandom));
        default: issue_request(REQ_FREE, CNT_W'(held + 1), '0);
      endcase
    end
  endtask

  initial begin
    pool_plan[0] = 9'd256;
    pool_plan[1] = 9'd2;
    pool_plan[2] = 9'd511;
    pool_plan[3] = CNT_W'($urandom_range(255, 2));
    pool_plan[4] = CNT_W'($urandom_range(255, 2));
    pool_plan[5] = 9'd64;
    pool_plan[6] = CNT_W'($urandom_range(255, 2));
    pool_plan[7] = 9'd256;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner requests on the full pool
    issue_request(REQ_ALLOC, 9'd0, 8'd0);
    issue_request(REQ_FREE, 9'd0, 8'd0);
    issue_request(REQ_UNKNOWN, 9'd511, 8'd255);
    issue_request(REQ_ALLOC, 9'd1, 8'd0);
    issue_request(REQ_FREE, 9'd1, 8'd0);
    issue_request(REQ_FREE, 9'd1, 8'd0);
    issue_request(REQ_ALLOC, 9'd256, 8'd255);
    issue_request(REQ_ALLOC, 9'd1, 8'd0);
    issue_request(REQ_FREE, 9'd2, 8'd255);
    issue_request(REQ_FREE, 9'd256, 8'd0);
    issue_request(REQ_ALLOC, 9'd257, 8'd0);
    issue_request(REQ_ALLOC, 9'd511, 8'd0);
    issue_request(REQ_ALLOC, 9'd10, 8'd0);

    // New size bounds frees at once but refills only on a pool reset
    wait_drained();
    write_pool_size(9'd4);
    issue_request(REQ_FREE, 9'd3, 8'd2);
    issue_request(REQ_FREE, 9'd4, 8'd0);
    issue_request(REQ_RESET, 9'd511, 8'd255);
    issue_request(REQ_ALLOC, 9'd4, 8'd0);
    issue_request(REQ_ALLOC, 9'd1, 8'd0);

    // Zero acts as one slot
    wait_drained();
    write_pool_size(9'd0);
    issue_request(REQ_RESET, 9'd0, 8'd0);
    issue_request(REQ_ALLOC, 9'd1, 8'd0);
    issue_request(REQ_FREE, 9'd1, 8'd1);
    issue_request(REQ_FREE, 9'd1, 8'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      write_pool_size(pool_plan[phase]);
      steady <= (phase == 4);
      issue_request(REQ_RESET, CNT_W'($urandom), SLOT_W'($urandom));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 20) stall_asked <= stall_asked + 1;
        random_request();
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ slot_free_list_allocator.f @@
rtl/sfla_pkg.sv
rtl/sfla_ram.sv
rtl/sfla_stack.sv
rtl/slot_free_list_allocator.sv
rtl/sfla_checker.sv
test/slot_pool_checker.sv
test/slot_free_list_allocator_tb.sv
